// ===== hdl/rgb_led_breathe_flash_pattern_core_defines.svh =====
// assertion macros for the rgb led breathe and flash pattern core
`ifndef RGB_LED_BREATHE_FLASH_PATTERN_CORE_DEFINES_SVH
`define RGB_LED_BREATHE_FLASH_PATTERN_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RLBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RLBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rlbf_pkg.sv =====
// types, constants and helpers for the rgb led breathe and flash pattern core
package rlbf_pkg;

    localparam int NOW_W   = 32;
    localparam int PHASE_W = 11;
    localparam int LIN_W   = 10;
    localparam int NUM_W   = 18;
    localparam int SETL_W  = 12;
    localparam int CNT_W   = 6;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [PHASE_W-1:0] BREATH_PERIOD_MS = 11'd2000;
    localparam logic [PHASE_W-1:0] BREATH_HALF_MS   = 11'd1000;
    localparam logic [NOW_W-1:0]   FLASH_LEN_MS     = 32'd600;
    localparam logic [9:0]         BLINK_ON_MS      = 10'd100;
    localparam logic [9:0]         BLINK_PERIOD_MS  = 10'd200;
    localparam logic [SETL_W-1:0]  SETTLE_RISE      = 12'd1000;
    localparam logic [SETL_W-1:0]  SETTLE_FALL      = 12'd3000;
    localparam logic [7:0]         FULL_LEVEL       = 8'd255;

    localparam logic [CNT_W-1:0]   MOD_STEPS = 6'(NOW_W - 1);
    localparam logic [CNT_W-1:0]   LIN_STEPS = 6'(NUM_W - 1);

    localparam logic [7:0] RED_RESET   = 8'd128;
    localparam logic [7:0] GREEN_RESET = 8'd0;
    localparam logic [7:0] BLUE_RESET  = 8'd128;

    localparam logic [1:0] REG_RED   = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BLUE  = 2'd2;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        link_up;
        logic        axis_moving;
        logic        flash_request;
    } tick_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } drive_t;

    // exact floor(x / 255) for x up to 65279
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ===== hdl/rgb_led_breathe_flash_pattern_core.sv =====
// rgb indicator driver: link flash, motion breathing, settle-out and colour scaling
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  tick    | in        | tick_valid/tick_ready  | tick_t  (time, link, motion, request)
//  drive   | out       | drive_valid/drive_ready| drive_t (red, green, blue)
//  apb     | in/out    | psel/penable, pready=1 | 8-bit colour registers at 0x0/0x4/0x8
//
//  one tick at a time: an accept step, a pass of the bit-serial mod 2000 unit, an
//  evaluate step, then the output step (flash and idle) or a pass of the same serial
//  unit dividing by 1000, then a squaring step and a level step before output
//  (breathing)
//  reset clears the control state and the indicator state and loads the colour defaults
//  a stalled drive transfer holds its result; the next tick is accepted meanwhile and
//  waits in the output step until the result register is free
module rgb_led_breathe_flash_pattern_core
    import rlbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              tick_valid,
    output logic              tick_ready,
    input  tick_t             tick,

    output logic              drive_valid,
    input  logic              drive_ready,
    output drive_t            drive,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    `include "rgb_led_breathe_flash_pattern_core_defines.svh"

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MOD  = 7'b0000010,
        ST_EVAL = 7'b0000100,
        ST_LIN  = 7'b0001000,
        ST_SQ   = 7'b0010000,
        ST_LVL  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    // control and indicator state (reset)
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                drive_valid_reg, drive_valid_next;
    logic [7:0]          red_reg, red_next;
    logic [7:0]          green_reg, green_next;
    logic [7:0]          blue_reg, blue_next;
    logic                link_seen_reg, link_seen_next;
    logic [NOW_W-1:0]    flash_start_reg, flash_start_next;
    logic                flash_active_reg, flash_active_next;
    logic                was_moving_reg, was_moving_next;
    logic [NOW_W-1:0]    settle_start_reg, settle_start_next;
    logic [SETL_W-1:0]   settle_len_reg, settle_len_next;

    // datapath (no reset)
    logic [NOW_W-1:0]    now_reg, now_next;
    logic                moving_reg, moving_next;
    logic [NOW_W-1:0]    dvd_reg, dvd_next;
    logic [PHASE_W-1:0]  rem_reg, rem_next;
    logic [7:0]          quo_reg, quo_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [7:0]          lin_reg, lin_next;
    logic [15:0]         prod_reg, prod_next;
    logic [7:0]          level_reg, level_next;
    drive_t              drive_reg, drive_next;

    // serial restoring divider step: one dividend bit per cycle
    logic [PHASE_W:0]    div_d;
    logic [PHASE_W:0]    trial;
    logic                trial_ge;
    logic [PHASE_W-1:0]  rem_step;
    logic [7:0]          quo_step;
    logic                div_busy;

    // evaluate-step terms
    logic [NOW_W-1:0]    flash_elapsed;
    logic [NOW_W-1:0]    settle_elapsed;
    logic [9:0]          blink_t;
    logic                blink_on;
    logic                rising_half;
    logic [LIN_W-1:0]    half_pos;
    logic [NUM_W-1:0]    lin_num;
    logic                tick_start;
    logic                breathe;
    logic                out_free;
    logic                out_load;
    logic                cfg_wr;

    assign div_d    = (state_reg == ST_LIN) ? {1'b0, BREATH_HALF_MS} : {1'b0, BREATH_PERIOD_MS};
    assign trial    = {rem_reg, dvd_reg[NOW_W-1]};
    assign trial_ge = (trial >= div_d);
    assign rem_step = trial_ge ? PHASE_W'(trial - div_d) : trial[PHASE_W-1:0];
    assign quo_step = {quo_reg[6:0], trial_ge};
    assign div_busy = (state_reg == ST_MOD) || (state_reg == ST_LIN);

    assign flash_elapsed  = now_reg - flash_start_reg;
    assign settle_elapsed = now_reg - settle_start_reg;
    assign blink_t        = flash_elapsed[9:0];
    // on during the first half of each 200 ms blink period (flash lasts below 600 ms)
    assign blink_on = (blink_t < BLINK_ON_MS)
                   || ((blink_t >= BLINK_PERIOD_MS) && (blink_t < BLINK_PERIOD_MS + BLINK_ON_MS))
                   || ((blink_t >= 10'(2 * BLINK_PERIOD_MS))
                       && (blink_t < 10'(2 * BLINK_PERIOD_MS) + BLINK_ON_MS));

    assign rising_half = (phase_reg < BREATH_HALF_MS);
    assign half_pos    = rising_half ? phase_reg[LIN_W-1:0]
                                     : LIN_W'(phase_reg - BREATH_HALF_MS);
    // position * 255, divided by 1000 on the serial unit
    assign lin_num     = {half_pos, 8'b0} - {8'b0, half_pos};

    assign tick_start = (tick.link_up & ~link_seen_reg) | tick.flash_request;
    assign out_free   = ~drive_valid_reg | drive_ready;
    assign out_load   = (state_reg == ST_OUT) & out_free;
    assign cfg_wr     = psel & penable & pwrite;

    assign tick_ready  = (state_reg == ST_IDLE);
    assign drive_valid = drive_valid_reg;
    assign drive       = drive_reg;
    assign pready      = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_RED:   prdata = {24'b0, red_reg};
            REG_GREEN: prdata = {24'b0, green_reg};
            REG_BLUE:  prdata = {24'b0, blue_reg};
            default:   prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        drive_valid_next  = drive_valid_reg & ~drive_ready;
        red_next          = red_reg;
        green_next        = green_reg;
        blue_next         = blue_reg;
        link_seen_next    = link_seen_reg;
        flash_start_next  = flash_start_reg;
        flash_active_next = flash_active_reg;
        was_moving_next   = was_moving_reg;
        settle_start_next = settle_start_reg;
        settle_len_next   = settle_len_reg;
        now_next          = now_reg;
        moving_next       = moving_reg;
        dvd_next          = dvd_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        phase_next        = phase_reg;
        lin_next          = lin_reg;
        prod_next         = prod_reg;
        level_next        = level_reg;
        drive_next        = drive_reg;
        breathe           = 1'b0;

        // colour registers; the bus is to write them between ticks, which the block does not enforce
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_RED:   red_next   = pwdata[7:0];
                REG_GREEN: green_next = pwdata[7:0];
                REG_BLUE:  blue_next  = pwdata[7:0];
                default:   ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    now_next       = tick.now_ms;
                    moving_next    = tick.axis_moving;
                    link_seen_next = tick.link_up;
                    // link rising edge or request restarts the flash sequence
                    if (tick_start)
                    begin
                        flash_start_next  = tick.now_ms;
                        flash_active_next = 1'b1;
                    end
                    dvd_next   = tick.now_ms;
                    rem_next   = '0;
                    cnt_next   = MOD_STEPS;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                dvd_next = {dvd_reg[NOW_W-2:0], 1'b0};
                rem_next = rem_step;
                if (cnt_reg == '0)
                begin
                    phase_next = rem_step;
                    state_next = ST_EVAL;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_EVAL:
            begin
                if (flash_active_reg && (flash_elapsed < FLASH_LEN_MS))
                begin
                    level_next = blink_on ? FULL_LEVEL : 8'd0;
                    state_next = ST_OUT;
                end
                else
                begin
                    flash_active_next = 1'b0;
                    was_moving_next   = moving_reg;
                    if (moving_reg)
                    begin
                        settle_len_next = '0;
                        breathe         = 1'b1;
                    end
                    else if (was_moving_reg)
                    begin
                        // keep breathing up to the next peak
                        settle_len_next   = rising_half
                                          ? SETTLE_RISE - {1'b0, phase_reg}
                                          : SETTLE_FALL - {1'b0, phase_reg};
                        settle_start_next = now_reg;
                        breathe           = 1'b1;
                    end
                    else if ((settle_len_reg != '0)
                             && (settle_elapsed < {{(NOW_W-SETL_W){1'b0}}, settle_len_reg}))
                    begin
                        breathe = 1'b1;
                    end
                    else
                    begin
                        settle_len_next = '0;
                        level_next      = FULL_LEVEL;
                    end

                    if (breathe)
                    begin
                        dvd_next   = {lin_num, {(NOW_W-NUM_W){1'b0}}};
                        rem_next   = '0;
                        quo_next   = '0;
                        cnt_next   = LIN_STEPS;
                        state_next = ST_LIN;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_LIN:
            begin
                dvd_next = {dvd_reg[NOW_W-2:0], 1'b0};
                rem_next = rem_step;
                quo_next = quo_step;
                if (cnt_reg == '0)
                begin
                    lin_next   = rising_half ? quo_step : FULL_LEVEL - quo_step;
                    state_next = ST_SQ;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_SQ:
            begin
                prod_next  = 16'(lin_reg) * 16'(lin_reg);
                state_next = ST_LVL;
            end
            ST_LVL:
            begin
                level_next = div255(prod_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    drive_next.red_out   = div255(16'(red_reg) * 16'(level_reg));
                    drive_next.green_out = div255(16'(green_reg) * 16'(level_reg));
                    drive_next.blue_out  = div255(16'(blue_reg) * 16'(level_reg));
                    drive_valid_next     = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            drive_valid_reg  <= 1'b0;
            red_reg          <= RED_RESET;
            green_reg        <= GREEN_RESET;
            blue_reg         <= BLUE_RESET;
            link_seen_reg    <= 1'b0;
            flash_start_reg  <= '0;
            flash_active_reg <= 1'b0;
            was_moving_reg   <= 1'b0;
            settle_start_reg <= '0;
            settle_len_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            drive_valid_reg  <= drive_valid_next;
            red_reg          <= red_next;
            green_reg        <= green_next;
            blue_reg         <= blue_next;
            link_seen_reg    <= link_seen_next;
            flash_start_reg  <= flash_start_next;
            flash_active_reg <= flash_active_next;
            was_moving_reg   <= was_moving_next;
            settle_start_reg <= settle_start_next;
            settle_len_reg   <= settle_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        moving_reg <= moving_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        phase_reg  <= phase_next;
        lin_reg    <= lin_next;
        prod_reg   <= prod_next;
        level_reg  <= level_next;
        drive_reg  <= drive_next;
    end

    // a transfer on the tick channel always starts the mod 2000 pass
    `RLBF_ASSERT_NEXT(a_tick_mod, tick_valid && tick_ready, state_reg == ST_MOD, "no phase pass")
    // the serial remainder stays below the active divisor
    `RLBF_ASSERT_NOW(a_rem_bound, div_busy, {1'b0, rem_reg} < div_d, "remainder out of range")
    // a settle window never exceeds one breathing cycle
    `RLBF_ASSERT_NOW(a_settle_bound, 1'b1, settle_len_reg <= {1'b0, BREATH_PERIOD_MS}, "bad settle")
    // leaving the output step with a free slot presents a result next cycle
    `RLBF_ASSERT_NEXT(a_out_presents, out_load, drive_valid && tick_ready, "result not presented")

endmodule
